>>> src/tbps_pkg.sv
package tbps_pkg;

   localparam int INDEX_W = 3;
   localparam int VALUE_W = 16;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_LOAD     = 1'b1;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] entry_index;
      logic [VALUE_W-1:0] priority_value;
      logic [VALUE_W-1:0] budget_value;
      logic [VALUE_W-1:0] sleep_value;
      logic               blocked_value;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] chosen_index;
      logic               idle;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clr_min;
      logic init_pass;
      logic init_refill;
      logic issue;
      logic mode_refill;
      logic resp_win;
      logic resp_idle;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic last_issue;
      logic found;
      logic any;
   } sts_type;

endpackage

>>> src/tbps_ctrl.sv
module tbps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              command,
   input  tbps_pkg::sts_type sts,
   output tbps_pkg::ctl_type ctl,
   output logic              busy
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_PASS       = 3'd1;
   localparam logic [2:0] S_PASS_END   = 3'd2;
   localparam logic [2:0] S_PASS_DEC   = 3'd3;
   localparam logic [2:0] S_REFILL     = 3'd4;
   localparam logic [2:0] S_REFILL_END = 3'd5;
   localparam logic [2:0] S_REFILL_DEC = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (command == tbps_pkg::CMD_LOAD) begin
                  ctl.load = 1'b1;
               end else begin
                  ctl.clr_min   = 1'b1;
                  ctl.init_pass = 1'b1;
                  state_in      = S_PASS;
               end
            end
         end
         S_PASS: begin
            ctl.issue = 1'b1;
            if (sts.last_issue) begin
               state_in = S_PASS_END;
            end
         end
         S_PASS_END: begin
            state_in = S_PASS_DEC;
         end
         S_PASS_DEC: begin
            if (sts.found) begin
               ctl.resp_win = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ctl.init_refill = 1'b1;
               state_in        = S_REFILL;
            end
         end
         S_REFILL: begin
            ctl.issue       = 1'b1;
            ctl.mode_refill = 1'b1;
            if (sts.last_issue) begin
               state_in = S_REFILL_END;
            end
         end
         S_REFILL_END: begin
            state_in = S_REFILL_DEC;
         end
         S_REFILL_DEC: begin
            if (!sts.any) begin
               ctl.resp_idle = 1'b1;
               state_in      = S_IDLE;
            end else begin
               ctl.init_pass = 1'b1;
               state_in      = S_PASS;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> src/tbps_datapath.sv
module tbps_datapath #(
   parameter int NUM_ENTRIES = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  tbps_pkg::req_type req_item,
   input  tbps_pkg::ctl_type ctl,
   output tbps_pkg::sts_type sts,
   output logic              rsp_strobe,
   output tbps_pkg::rsp_type rsp_item
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CMP_W = (IDX_W + 1 > tbps_pkg::INDEX_W) ? IDX_W + 1 : tbps_pkg::INDEX_W;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] prio;
      logic [COUNT_WIDTH-1:0] budget;
      logic [COUNT_WIDTH-1:0] sleep;
      logic                   blocked;
   } entry_type;

   entry_type mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff;

   entry_type              rdata_ff;
   logic                   rvalid_ff;
   logic                   proc_valid_ff;
   logic                   proc_refill_ff;
   logic [IDX_W-1:0]       proc_idx_ff;
   logic [IDX_W-1:0]       cnt_ff;
   logic [IDX_W-1:0]       cnt_in;
   logic [COUNT_WIDTH-1:0] best_ff;
   logic [COUNT_WIDTH-1:0] best_in;
   logic [IDX_W-1:0]       win_ff;
   logic [IDX_W-1:0]       win_in;
   logic [COUNT_WIDTH-1:0] min_ff;
   logic [COUNT_WIDTH-1:0] min_in;
   logic                   any_ff;
   logic                   any_in;
   logic                   rsp_strobe_ff;
   tbps_pkg::rsp_type      rsp_ff;

   logic [CMP_W-1:0]       load_idx;
   logic                   load_ok;
   entry_type              ent;
   entry_type              proc_wdata;
   entry_type              wdata;
   logic                   proc_wr;
   logic                   mem_we;
   logic [IDX_W-1:0]       waddr;
   logic                   sleep_gt;
   logic [COUNT_WIDTH-1:0] sleep_dec;
   logic                   cand;

   assign load_idx = CMP_W'(req_item.entry_index);
   assign load_ok  = ctl.load && (load_idx < CMP_W'(NUM_ENTRIES));

   assign ent       = rvalid_ff ? rdata_ff : '0;
   // sleep minus the collapsed wait, then one more pass of countdown
   assign sleep_gt  = ent.sleep > min_ff;
   assign sleep_dec = ent.sleep - min_ff - COUNT_WIDTH'(1);
   assign cand      = !ent.blocked && (ent.prio != '0);

   always_comb begin
      proc_wdata = ent;
      proc_wr    = 1'b0;
      best_in    = best_ff;
      win_in     = win_ff;
      min_in     = min_ff;
      any_in     = any_ff;
      if (proc_valid_ff) begin
         if (proc_refill_ff) begin
            proc_wr           = 1'b1;
            proc_wdata.budget = ent.prio;
            if (cand && (!any_ff || ent.sleep < min_ff)) begin
               min_in = ent.sleep;
            end
            if (cand) begin
               any_in = 1'b1;
            end
         end else if (!ent.blocked) begin
            proc_wr          = 1'b1;
            proc_wdata.sleep = sleep_gt ? sleep_dec : '0;
            if (!sleep_gt && ent.budget > best_ff) begin
               best_in = ent.budget;
               win_in  = proc_idx_ff;
            end
         end
      end
      if (ctl.clr_min) begin
         min_in = '0;
      end
      if (ctl.init_pass) begin
         best_in = '0;
      end
      if (ctl.init_refill) begin
         any_in = 1'b0;
      end
   end

   always_comb begin
      if (load_ok) begin
         mem_we        = 1'b1;
         waddr         = load_idx[IDX_W-1:0];
         wdata.prio    = COUNT_WIDTH'(req_item.priority_value);
         wdata.budget  = COUNT_WIDTH'(req_item.budget_value);
         wdata.sleep   = COUNT_WIDTH'(req_item.sleep_value);
         wdata.blocked = req_item.blocked_value;
      end else begin
         mem_we = proc_wr;
         waddr  = proc_idx_ff;
         wdata  = proc_wdata;
      end
   end

   // the counter stops on the last entry so it never addresses past the table
   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.init_pass || ctl.init_refill) begin
         cnt_in = '0;
      end else if (ctl.issue && !sts.last_issue) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         rvalid_ff      <= 1'b0;
         proc_valid_ff  <= 1'b0;
         proc_refill_ff <= 1'b0;
         cnt_ff         <= '0;
         best_ff        <= '0;
         min_ff         <= '0;
         any_ff         <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rvalid_ff      <= valid_ff[cnt_ff];
         proc_valid_ff  <= ctl.issue;
         proc_refill_ff <= ctl.mode_refill;
         cnt_ff         <= cnt_in;
         best_ff        <= best_in;
         min_ff         <= min_in;
         any_ff         <= any_in;
         rsp_strobe_ff  <= ctl.resp_win || ctl.resp_idle;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= cnt_ff;
      win_ff      <= win_in;
      if (ctl.resp_win) begin
         rsp_ff.chosen_index <= tbps_pkg::INDEX_W'(win_ff);
         rsp_ff.idle         <= 1'b0;
      end else if (ctl.resp_idle) begin
         rsp_ff.chosen_index <= '0;
         rsp_ff.idle         <= 1'b1;
      end
   end

   assign sts.last_issue = (cnt_ff == IDX_W'(NUM_ENTRIES - 1));
   assign sts.found      = (best_ff != '0);
   assign sts.any        = any_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_item       = rsp_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_idle_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.idle |-> rsp_ff.chosen_index == '0)
      else $error("idle result with nonzero index");

   a_win_has_budget: assert property (@(posedge clock) disable iff (reset)
      ctl.resp_win |-> (best_ff != '0) && !ctl.resp_idle)
      else $error("winner reported without a positive budget");

   a_no_load_in_sweep: assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> !ctl.load)
      else $error("load during a table sweep");

endmodule

>>> src/tick_budget_priority_scheduler.sv
// Task scheduler over a table of NUM_ENTRIES entries (priority, tick budget,
// sleep countdown, blocked flag) held in one memory with a registered read. A
// load item is written into the table while idle and gives no result. A
// schedule item walks the table one entry per cycle: a pass issues each entry,
// then finishes its last update and decides; if it finds no winner a refill
// sweep follows and, unless the table is idle, a second pass that always wins.
// busy is high from the start of the first pass up to and including the final
// decision state, and stays low for a load item. Each result appears
// on rsp_item for exactly one cycle with rsp_strobe and cannot be held off, so
// it must be captured when strobed; it shows in the cycle busy falls.
module tick_budget_priority_scheduler #(
   parameter int NUM_ENTRIES = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tbps_pkg::req_type req_item,
   output logic              rsp_strobe,
   output tbps_pkg::rsp_type rsp_item
);

   tbps_pkg::ctl_type ctl;
   tbps_pkg::sts_type sts;

   tbps_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_item.command),
      .sts     (sts),
      .ctl     (ctl),
      .busy    (busy)
   );

   tbps_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
